>>> hw/rtl/cc_pkg.sv
// shared widths, payload structs and stage structs for the circumcenter pipeline
package cc_pkg;

    // coordinate width of the input points
    localparam int COORD_BITS = 16;

    // point differences relative to point a
    localparam int DIFF_W = COORD_BITS + 1;
    // squared norms, determinant and doubled determinant (signed)
    localparam int SQ_W = 2 * COORD_BITS + 3;
    // split of the wide operand for the partial products
    localparam int LO_W = (SQ_W + 1) / 2;
    localparam int HI_W = SQ_W - LO_W;
    localparam int PP_LO_W = LO_W + 1 + DIFF_W;
    localparam int PP_HI_W = HI_W + DIFF_W;
    // full product and numerator widths
    localparam int PROD_W = SQ_W + DIFF_W;
    localparam int NUM_W = PROD_W + 2;
    // dividend width seen by the divider, at least one bit above the quotient
    localparam int Q_W = 32;
    localparam int DIV_N_W = (NUM_W > Q_W + 1) ? NUM_W : Q_W + 1;
    localparam int REM_W = SQ_W + 1;
    localparam int CMP_W = (DIV_N_W - Q_W > REM_W) ? DIV_N_W - Q_W : REM_W;

    // saturation limits of the center coordinates
    localparam logic [Q_W-1:0] SAT_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] SAT_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // input transfer
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_a_x;
        logic signed [COORD_BITS-1:0] point_a_y;
        logic signed [COORD_BITS-1:0] point_b_x;
        logic signed [COORD_BITS-1:0] point_b_y;
        logic signed [COORD_BITS-1:0] point_c_x;
        logic signed [COORD_BITS-1:0] point_c_y;
    } points_t;

    // output transfer
    typedef struct packed {
        logic signed [Q_W-1:0] center_x;
        logic signed [Q_W-1:0] center_y;
        logic                  found;
        logic                  saturated;
    } center_t;

    // front end to numerator stages
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [DIFF_W-1:0]     bx;
        logic signed [DIFF_W-1:0]     by;
        logic signed [DIFF_W-1:0]     cx;
        logic signed [DIFF_W-1:0]     cy;
        logic signed [SQ_W-1:0]       nb;
        logic signed [SQ_W-1:0]       nc;
        logic signed [SQ_W-1:0]       den;
    } front_t;

    // numerator stages to divider
    typedef struct packed {
        logic [DIV_N_W-1:0] num_mag;
        logic [SQ_W-1:0]    den_mag;
        logic               num_neg;
        logic               found;
    } div_in_t;

    // divider to output stage
    typedef struct packed {
        logic [Q_W-1:0] quot;
        logic           ovf;
        logic           neg;
        logic           found;
    } div_out_t;

endpackage

>>> hw/rtl/cc_front.sv
// front end: differences, squares and cross products, norms and determinant
module cc_front
    import cc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  points_t pts,
    output logic    out_valid,
    output front_t  fout
);

    logic                         v1_reg, v2_reg, v3_reg;
    logic signed [COORD_BITS-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [DIFF_W-1:0]     bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [DIFF_W-1:0]     bx2_reg, by2_reg, cx2_reg, cy2_reg;
    logic signed [DIFF_W-1:0]     bx_next, by_next, cx_next, cy_next;
    logic signed [2*DIFF_W-1:0]   sq_bx_reg, sq_by_reg, sq_cx_reg, sq_cy_reg;
    logic signed [2*DIFF_W-1:0]   bxcy_reg, bycx_reg;
    logic signed [SQ_W-1:0]       det_next;
    front_t                       f3_reg, f3_next;

    // stage 1: offsets of b and c from a
    always_comb
    begin
        bx_next = {pts.point_b_x[COORD_BITS-1], pts.point_b_x}
                - {pts.point_a_x[COORD_BITS-1], pts.point_a_x};
        by_next = {pts.point_b_y[COORD_BITS-1], pts.point_b_y}
                - {pts.point_a_y[COORD_BITS-1], pts.point_a_y};
        cx_next = {pts.point_c_x[COORD_BITS-1], pts.point_c_x}
                - {pts.point_a_x[COORD_BITS-1], pts.point_a_x};
        cy_next = {pts.point_c_y[COORD_BITS-1], pts.point_c_y}
                - {pts.point_a_y[COORD_BITS-1], pts.point_a_y};
    end

    // stage 3: norms and doubled determinant
    always_comb
    begin
        det_next      = SQ_W'(bxcy_reg) - SQ_W'(bycx_reg);
        f3_next.ax    = ax2_reg;
        f3_next.ay    = ay2_reg;
        f3_next.bx    = bx2_reg;
        f3_next.by    = by2_reg;
        f3_next.cx    = cx2_reg;
        f3_next.cy    = cy2_reg;
        f3_next.nb    = SQ_W'(sq_bx_reg) + SQ_W'(sq_by_reg);
        f3_next.nc    = SQ_W'(sq_cx_reg) + SQ_W'(sq_cy_reg);
        f3_next.den   = {det_next[SQ_W-2:0], 1'b0};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= pts.point_a_x;
            ay1_reg   <= pts.point_a_y;
            bx1_reg   <= bx_next;
            by1_reg   <= by_next;
            cx1_reg   <= cx_next;
            cy1_reg   <= cy_next;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            sq_bx_reg <= bx1_reg * bx1_reg;
            sq_by_reg <= by1_reg * by1_reg;
            sq_cx_reg <= cx1_reg * cx1_reg;
            sq_cy_reg <= cy1_reg * cy1_reg;
            bxcy_reg  <= bx1_reg * cy1_reg;
            bycx_reg  <= by1_reg * cx1_reg;
            f3_reg    <= f3_next;
        end
    end

    assign out_valid = v3_reg;
    assign fout      = f3_reg;

endmodule

>>> hw/rtl/cc_numer.sv
// numerator stages: split products, recombination, sums and sign handling
module cc_numer
    import cc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  front_t  fin,
    output logic    out_valid,
    output div_in_t x_out,
    output div_in_t y_out
);

    logic signed [SQ_W-1:0]    wop [6];
    logic signed [DIFF_W-1:0]  cop [6];
    logic signed [PP_LO_W-1:0] pl_reg [6];
    logic signed [PP_HI_W-1:0] ph_reg [6];
    logic signed [PROD_W-1:0]  prod_reg [6];
    logic signed [SQ_W-1:0]    den4_reg, den5_reg, den6_reg;
    logic signed [NUM_W-1:0]   numx_reg, numy_reg;
    logic                      v4_reg, v5_reg, v6_reg, v7_reg;
    logic [NUM_W-1:0]          magx, magy;
    logic [SQ_W-1:0]           dmag;
    div_in_t                   x_next, y_next, x_reg, y_reg;

    // operand pairs of the six numerator products
    always_comb
    begin
        wop[0] = fin.nb;  cop[0] = fin.cy;
        wop[1] = fin.nc;  cop[1] = fin.by;
        wop[2] = fin.den; cop[2] = {fin.ax[COORD_BITS-1], fin.ax};
        wop[3] = fin.nc;  cop[3] = fin.bx;
        wop[4] = fin.nb;  cop[4] = fin.cx;
        wop[5] = fin.den; cop[5] = {fin.ay[COORD_BITS-1], fin.ay};
    end

    // stages 4 and 5: half products, then shifted recombination
    for (genvar i = 0; i < 6; i++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pl_reg[i]   <= $signed({1'b0, wop[i][LO_W-1:0]}) * cop[i];
                ph_reg[i]   <= $signed(wop[i][SQ_W-1:LO_W]) * cop[i];
                prod_reg[i] <= (PROD_W'(ph_reg[i]) <<< LO_W) + PROD_W'(pl_reg[i]);
            end
        end
    end

    // stage 7: magnitudes and quotient sign
    always_comb
    begin
        magx = numx_reg[NUM_W-1] ? NUM_W'(-numx_reg) : numx_reg;
        magy = numy_reg[NUM_W-1] ? NUM_W'(-numy_reg) : numy_reg;
        dmag = den6_reg[SQ_W-1] ? SQ_W'(-den6_reg) : den6_reg;
        x_next.num_mag = DIV_N_W'(magx);
        x_next.den_mag = dmag;
        x_next.num_neg = numx_reg[NUM_W-1] ^ den6_reg[SQ_W-1];
        x_next.found   = (den6_reg != '0);
        y_next.num_mag = DIV_N_W'(magy);
        y_next.den_mag = dmag;
        y_next.num_neg = numy_reg[NUM_W-1] ^ den6_reg[SQ_W-1];
        y_next.found   = (den6_reg != '0);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // stage 6 sums and data carried alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den4_reg <= fin.den;
            den5_reg <= den4_reg;
            den6_reg <= den5_reg;
            numx_reg <= NUM_W'(prod_reg[0]) - NUM_W'(prod_reg[1]) + NUM_W'(prod_reg[2]);
            numy_reg <= NUM_W'(prod_reg[3]) - NUM_W'(prod_reg[4]) + NUM_W'(prod_reg[5]);
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign out_valid = v7_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;

endmodule

>>> hw/rtl/cc_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow check
module cc_div
    import cc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  div_in_t  din,
    output logic     out_valid,
    output div_out_t dout
);

    logic [REM_W-1:0] rem_reg  [Q_W+1];
    logic [Q_W-1:0]   low_reg  [Q_W+1];
    logic [Q_W-1:0]   quot_reg [Q_W+1];
    logic [SQ_W-1:0]  den_reg  [Q_W+1];
    logic             ovf_reg  [Q_W+1];
    logic             neg_reg  [Q_W+1];
    logic             fnd_reg  [Q_W+1];
    logic             v_reg    [Q_W+1];
    logic [DIV_N_W-Q_W-1:0] top_bits;

    // entry stage: quotient overflows 32 bits when the top part reaches the divisor
    assign top_bits = din.num_mag[DIV_N_W-1:Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= REM_W'(top_bits);
            low_reg[0]  <= din.num_mag[Q_W-1:0];
            quot_reg[0] <= '0;
            den_reg[0]  <= din.den_mag;
            ovf_reg[0]  <= (CMP_W'(top_bits) >= CMP_W'(din.den_mag));
            neg_reg[0]  <= din.num_neg;
            fnd_reg[0]  <= din.found;
        end
    end

    // one shift, compare and subtract per stage
    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb
        begin
            trial = {rem_reg[k][REM_W-2:0], low_reg[k][Q_W-1]};
            ge    = (trial >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? (trial - {1'b0, den_reg[k]}) : trial;
                low_reg[k+1]  <= {low_reg[k][Q_W-2:0], 1'b0};
                quot_reg[k+1] <= {quot_reg[k][Q_W-2:0], ge};
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                fnd_reg[k+1]  <= fnd_reg[k];
            end
        end
    end

    assign out_valid  = v_reg[Q_W];
    assign dout.quot  = quot_reg[Q_W];
    assign dout.ovf   = ovf_reg[Q_W];
    assign dout.neg   = neg_reg[Q_W];
    assign dout.found = fnd_reg[Q_W];

endmodule

>>> hw/rtl/circumcenter_three_points_top.sv
// Circumcenter of three points with signed 16-bit coordinates. One triple is
// accepted every cycle unless stalled, and each gives exactly one result: three
// front-end stages (offsets, products, norms and determinant), four numerator
// stages (split multiplies, recombination, sums, magnitudes), a divider of one
// entry stage plus one stage per quotient bit (33) and the output register.
// The center is the exact quotient truncated toward zero and clipped to signed
// 32 bits, with saturated set on clipping; collinear or coincident points
// give found = 0 and a zero center. The whole pipeline holds while a finished
// result waits under center_stall, so point_stall follows that condition.
module circumcenter_three_points_top
    import cc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    point_valid,
    output logic    point_stall,
    input  points_t points,
    output logic    center_valid,
    input  logic    center_stall,
    output center_t center
);

    logic     en;
    logic     front_valid, numer_valid, divx_valid, divy_valid;
    front_t   front_data;
    div_in_t  x_in, y_in;
    div_out_t x_res, y_res;
    logic     sat_x, sat_y;
    logic [Q_W-1:0] val_x, val_y;
    center_t  center_next, center_reg;
    logic     center_valid_reg;

    // pipeline advances unless a result is held at the output
    assign en          = !(center_valid_reg && center_stall);
    assign point_stall = !en;

    cc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (point_valid),
        .pts       (points),
        .out_valid (front_valid),
        .fout      (front_data)
    );

    cc_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .fin       (front_data),
        .out_valid (numer_valid),
        .x_out     (x_in),
        .y_out     (y_in)
    );

    cc_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (numer_valid),
        .din       (x_in),
        .out_valid (divx_valid),
        .dout      (x_res)
    );

    cc_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (numer_valid),
        .din       (y_in),
        .out_valid (divy_valid),
        .dout      (y_res)
    );

    // sign and saturation of both coordinates
    always_comb
    begin
        if (x_res.neg)
        begin
            sat_x = x_res.ovf || (x_res.quot > SAT_MIN);
            val_x = sat_x ? SAT_MIN : Q_W'(-x_res.quot);
        end
        else
        begin
            sat_x = x_res.ovf || x_res.quot[Q_W-1];
            val_x = sat_x ? SAT_MAX : x_res.quot;
        end
        if (y_res.neg)
        begin
            sat_y = y_res.ovf || (y_res.quot > SAT_MIN);
            val_y = sat_y ? SAT_MIN : Q_W'(-y_res.quot);
        end
        else
        begin
            sat_y = y_res.ovf || y_res.quot[Q_W-1];
            val_y = sat_y ? SAT_MAX : y_res.quot;
        end
        if (x_res.found)
        begin
            center_next.center_x  = val_x;
            center_next.center_y  = val_y;
            center_next.found     = 1'b1;
            center_next.saturated = sat_x || sat_y;
        end
        else
        begin
            center_next.center_x  = '0;
            center_next.center_y  = '0;
            center_next.found     = 1'b0;
            center_next.saturated = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            center_valid_reg <= divx_valid && divy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            center_reg <= center_next;
        end
    end

    assign center_valid = center_valid_reg;
    assign center       = center_reg;

`ifndef SYNTH
    // both divider lanes stay in step
    assert property (@(posedge clk) disable iff (!rst_n) divx_valid == divy_valid)
        else $error("divider lanes out of step");

    // no center means a zero, unsaturated result
    assert property (@(posedge clk) disable iff (!rst_n)
        (center_valid && !center.found) |->
        (center.center_x == 0 && center.center_y == 0 && !center.saturated))
        else $error("collinear result not cleared");

    // a saturated result has a coordinate at a limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (center_valid && center.saturated) |->
        (center.center_x == SAT_MAX || center.center_x == SAT_MIN ||
         center.center_y == SAT_MAX || center.center_y == SAT_MIN))
        else $error("saturated flag without clipped coordinate");

    // input holds exactly while a result waits under stall
    assert property (@(posedge clk) disable iff (!rst_n)
        point_stall == (center_valid && center_stall))
        else $error("input stall does not follow output stall");
`endif

endmodule
